>>> sv/abrf_pkg.sv
// Shared types and constants for the atomic byte ring FIFO.
// No dependencies; every other file of the block imports this package.
package abrf_pkg;

  localparam int DEPTH_DEF     = 4096;
  localparam int MAX_BURST_DEF = 64;

  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 13;
  localparam int S_TDATA_W  = 40;
  localparam int S_TUSER_W  = 3;
  localparam int M_TDATA_W  = 48;
  localparam int M_TUSER_W  = 2;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_PEEK  = 2'd2,
    OP_SKIP  = 2'd3
  } op_t;

  typedef struct packed {
    op_t               opcode;
    logic [BYTE_W-1:0] data_byte;
    logic [LEN_W-1:0]  packet_length;
    logic              first_byte;
    logic              last_byte;
    logic [LEN_W-1:0]  request_length;
  } item_t;

  // Result fields other than the byte itself, which comes from the ring.
  typedef struct packed {
    logic             byte_valid;
    logic             last_result;
    logic             accepted;
    logic [LEN_W-1:0] count;
    logic [LEN_W-1:0] available;
    logic [LEN_W-1:0] free_space;
  } res_t;

endpackage

>>> sv/abrf_ring.sv
// Byte storage of the ring: one write port, one read port, registered read data.
// Depends on abrf_pkg.
module abrf_ring #(
  parameter int DEPTH = abrf_pkg::DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [$clog2(DEPTH)-1:0]         wr_addr,
  input  logic [abrf_pkg::BYTE_W-1:0]      wr_data,
  input  logic                             rd_en,
  input  logic [$clog2(DEPTH)-1:0]         rd_addr,
  output logic [abrf_pkg::BYTE_W-1:0]      rd_data
);
  import abrf_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/abrf_seq.sv
// Sequencer of the ring FIFO: pointers, packet state, clamp arithmetic and result register.
// Depends on abrf_pkg; drives the ports of abrf_ring.
module abrf_seq #(
  parameter int DEPTH     = abrf_pkg::DEPTH_DEF,
  parameter int MAX_BURST = abrf_pkg::MAX_BURST_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  abrf_pkg::item_t             item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output abrf_pkg::res_t              res,
  output logic                        wr_en,
  output logic [$clog2(DEPTH)-1:0]    wr_addr,
  output logic [abrf_pkg::BYTE_W-1:0] wr_data,
  output logic                        rd_en,
  output logic [$clog2(DEPTH)-1:0]    rd_addr
);
  import abrf_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int PW = AW + 1;
  localparam int XW = (PW > LEN_W) ? PW : LEN_W;
  localparam int BW = $clog2(MAX_BURST + 1);
  localparam logic [PW-1:0] DEPTH_PW = PW'(DEPTH);
  localparam logic [XW-1:0] BURST_XW = XW'(MAX_BURST);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_STAT = 5'b00100,
    S_RD   = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t            state;
  logic [PW-1:0]     wp;
  logic [PW-1:0]     rp;
  logic [PW-1:0]     off;
  logic              kept;
  logic [LEN_W-1:0]  total;

  item_t             item_r;
  logic [AW-1:0]     start;
  logic [BW-1:0]     idx;
  logic [BW-1:0]     nb;
  logic              burst;

  // shared occupancy unit, reads the live pointers
  logic [PW-1:0]     held;
  logic [PW-1:0]     free;
  logic              kept_eff;
  logic [LEN_W-1:0]  total_eff;
  logic [PW-1:0]     off_eff;
  logic              do_store;
  logic [PW-1:0]     off_new;
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     n_skip;
  logic [XW-1:0]     lim;
  logic [BW-1:0]     n_burst;

  assign held = wp - rp;
  assign free = DEPTH_PW - held;

  always_comb begin
    kept_eff  = item_r.first_byte ? (XW'(item_r.packet_length) <= XW'(free)) : kept;
    total_eff = item_r.first_byte ? item_r.packet_length : total;
    off_eff   = item_r.first_byte ? '0 : off;
    do_store  = kept_eff && (XW'(off_eff) < XW'(total_eff));
    off_new   = do_store ? off_eff + PW'(1) : off_eff;
    wr_ptr    = wp + off_eff;
    n_skip    = (XW'(item_r.request_length) > XW'(held)) ? held
                                                         : PW'(item_r.request_length);
    lim       = (XW'(held) > BURST_XW) ? BURST_XW : XW'(held);
    n_burst   = (XW'(item_r.request_length) > lim) ? BW'(lim)
                                                   : BW'(item_r.request_length);
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign wr_en     = (state == S_EXEC) && (item_r.opcode == OP_WRITE) && do_store;
  assign wr_addr   = wr_ptr[AW-1:0];
  assign wr_data   = item_r.data_byte;
  assign rd_en     = (state == S_RD);
  assign rd_addr   = start + AW'(idx);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      wp    <= '0;
      rp    <= '0;
      off   <= '0;
      kept  <= 1'b0;
      total <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (item_r.opcode)
            OP_WRITE: begin
              total <= total_eff;
              if (item_r.last_byte) begin
                kept <= 1'b0;
                off  <= '0;
                if (kept_eff) begin
                  wp <= wp + off_new;
                end
              end else begin
                kept <= kept_eff;
                off  <= off_new;
              end
            end
            OP_SKIP: begin
              rp <= rp + n_skip;
            end
            OP_READ: begin
              rp <= rp + PW'(n_burst);
            end
            default: begin
              // peek leaves the pointers alone
            end
          endcase
          state <= S_STAT;
        end
        S_STAT: begin
          state <= burst ? S_RD : S_OUT;
        end
        S_RD: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            state <= (burst && !res.last_result) ? S_RD : S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload: item copy, burst bookkeeping, result register
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          item_r <= item;
        end
      end
      S_EXEC: begin
        res.byte_valid  <= 1'b0;
        res.last_result <= 1'b1;
        res.accepted    <= 1'b0;
        res.count       <= '0;
        burst           <= 1'b0;
        idx             <= '0;
        nb              <= n_burst;
        start           <= rp[AW-1:0];
        case (item_r.opcode)
          OP_WRITE: begin
            res.accepted <= kept_eff;
            if (item_r.last_byte && kept_eff) begin
              res.count <= LEN_W'(off_new);
            end
          end
          OP_SKIP: begin
            res.count <= LEN_W'(n_skip);
          end
          default: begin
            res.count <= LEN_W'(n_burst);
            burst     <= (n_burst != '0);
          end
        endcase
      end
      S_STAT: begin
        // occupancy after the pointer update
        res.available  <= LEN_W'(held);
        res.free_space <= LEN_W'(free);
      end
      S_RD: begin
        res.byte_valid  <= 1'b1;
        res.last_result <= (idx + BW'(1) == nb);
      end
      S_OUT: begin
        if (out_ready && burst && !res.last_result) begin
          idx <= idx + BW'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> sv/atomic_byte_ring_fifo.sv
// Top level of the atomic byte ring FIFO: stream ports, field packing, sequencer and ring.
// Depends on abrf_pkg, abrf_seq and abrf_ring.
//
//   channel  dir  tdata (low bit up)                               tuser                 tlast
//   s_*      in   data_byte, packet_length, request_length, pad    opcode, first_byte    last_byte
//   m_*      out  out_byte, count, available, free_space, pad      byte_valid, accepted  last_result
//
// One item at a time. Write, skip and an empty read or peek: accept, the EXEC and STAT
// states, then the result waits in the output register. A read or peek of n bytes passes
// EXEC, STAT and RD to its first result and OUT and RD per further byte, set by the single
// registered read port of the ring. s_tready is low from acceptance until the last
// result has been transferred; a stall on m_tready holds the result. rst is synchronous
// and clears the pointers and packet state; the ring itself needs no clearing.
module atomic_byte_ring_fifo #(
  parameter int DEPTH     = abrf_pkg::DEPTH_DEF,
  parameter int MAX_BURST = abrf_pkg::MAX_BURST_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [abrf_pkg::S_TDATA_W-1:0] s_tdata,   // data_byte, packet_length, request_length
  input  logic [abrf_pkg::S_TUSER_W-1:0] s_tuser,   // opcode[1:0], first_byte
  input  logic                           s_tlast,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [abrf_pkg::M_TDATA_W-1:0] m_tdata,   // out_byte, count, available, free_space
  output logic [abrf_pkg::M_TUSER_W-1:0] m_tuser,   // byte_valid, accepted
  output logic                           m_tlast
);
  import abrf_pkg::*;

  localparam int AW = $clog2(DEPTH);

  item_t             item;
  res_t              res;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [BYTE_W-1:0] wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [BYTE_W-1:0] rd_data;
  logic [BYTE_W-1:0] out_byte;

  always_comb begin
    item.opcode         = op_t'(s_tuser[1:0]);
    item.first_byte     = s_tuser[2];
    item.last_byte      = s_tlast;
    item.data_byte      = s_tdata[7:0];
    item.packet_length  = s_tdata[20:8];
    item.request_length = s_tdata[33:21];
  end

  abrf_seq #(
    .DEPTH     (DEPTH),
    .MAX_BURST (MAX_BURST)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .item      (item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .res       (res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr)
  );

  abrf_ring #(
    .DEPTH (DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_byte = res.byte_valid ? rd_data : '0;
  assign m_tdata  = {1'b0, res.free_space, res.available, res.count, out_byte};
  assign m_tuser  = {res.accepted, res.byte_valid};
  assign m_tlast  = res.last_result;

endmodule

>>> sv/abrf_checker.sv
// Port-level checks for atomic_byte_ring_fifo, bound to the top level.
// Depends on abrf_pkg and atomic_byte_ring_fifo.
module abrf_checker #(
  parameter int DEPTH = abrf_pkg::DEPTH_DEF
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [abrf_pkg::M_TDATA_W-1:0] m_tdata,
  input logic [abrf_pkg::M_TUSER_W-1:0] m_tuser,
  input logic                           m_tlast
);
  import abrf_pkg::*;

  localparam logic [LEN_W-1:0] DEPTH_L = LEN_W'(DEPTH);

  logic [LEN_W-1:0] occ_sum;
  assign occ_sum = m_tdata[33:21] + m_tdata[46:34];

  // held plus free always covers the ring
  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> occ_sum == DEPTH_L)
    else $error("available plus free_space differs from the ring depth");

  a_zero_byte: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[7:0] == 8'd0)
    else $error("out_byte nonzero on a result without a byte");

  // an accepted write result never carries a byte and always closes its item
  a_write_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> !m_tuser[0] && m_tlast)
    else $error("accepted set on a byte result or a non-final result");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input ready while a result is pending");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

endmodule

bind atomic_byte_ring_fifo abrf_checker #(.DEPTH(DEPTH)) u_abrf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

>>> tb/sv/atomic_byte_ring_fifo_tb.sv
// Testbench for the atomic byte ring FIFO: directed cases, free-space edge packets, then random traffic.
// Each result is checked against a predictor that runs in this file. Depends on abrf_pkg.
module atomic_byte_ring_fifo_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import abrf_pkg::*;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int MAX_BURST   = MAX_BURST_DEF;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int RANDOM_ITEMS = 120;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 3_000_000;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    res_t              info;
  } ring_result_t;

  typedef struct {
    item_t it;
    bit    idle_first;  // wait until nothing is outstanding before sending
    bit    hold_rx;     // starts a long receiver hold-off when sent
  } pending_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [S_TUSER_W-1:0] s_tuser = '0;
  logic                 s_tlast = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [M_TUSER_W-1:0] m_tuser;
  logic                 m_tlast;

  atomic_byte_ring_fifo u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // data_byte, packet_length, request_length, pad
    .s_tuser  (s_tuser),   // opcode[1:0], first_byte
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // out_byte, count, available, free_space, pad
    .m_tuser  (m_tuser),   // byte_valid, accepted
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predictor state
  logic [BYTE_W-1:0] ring_mem [DEPTH];
  logic [LEN_W-1:0]  wr_ptr = '0;
  logic [LEN_W-1:0]  rd_ptr = '0;
  logic [LEN_W-1:0]  pkt_off = '0;
  logic [LEN_W-1:0]  pkt_total = '0;
  logic              pkt_kept = 1'b0;

  ring_result_t expected_results[$];
  pending_t     pending_items[$];

  int errors = 0;
  int accept_cnt = 0;
  int offer_cnt = 0;
  int result_cnt = 0;
  int hold_req_cnt = 0;
  int cycle_cnt = 0;

  function automatic ring_result_t make_result(logic [BYTE_W-1:0] b, logic valid, logic last,
                                               logic acc, logic [LEN_W-1:0] cnt);
    ring_result_t r;
    logic [LEN_W-1:0] fill;
    fill = wr_ptr - rd_ptr;
    r.out_byte         = b;
    r.info.byte_valid  = valid;
    r.info.last_result = last;
    r.info.accepted    = acc;
    r.info.count       = cnt;
    r.info.available   = fill;
    r.info.free_space  = LEN_W'(DEPTH) - fill;
    return r;
  endfunction

  task automatic predict_results(input item_t it);
    logic [LEN_W-1:0] fill;
    logic [LEN_W-1:0] n;
    logic [LEN_W-1:0] slot;
    logic [LEN_W-1:0] start;
    logic [LEN_W-1:0] cnt;
    logic             acc;
    fill = wr_ptr - rd_ptr;
    n = it.request_length;
    if (n > fill) n = fill;
    case (it.opcode)
      OP_WRITE: begin
        cnt = '0;
        if (it.first_byte) begin
          pkt_total = it.packet_length;
          pkt_off   = '0;
          pkt_kept  = int'(it.packet_length) <= DEPTH - int'(fill);
        end
        // bytes past the declared length are dropped silently
        if (pkt_kept && pkt_off < pkt_total) begin
          slot = wr_ptr + pkt_off;
          ring_mem[slot[ADDR_W-1:0]] = it.data_byte;
          pkt_off++;
        end
        acc = pkt_kept;
        if (it.last_byte) begin
          if (pkt_kept) begin
            cnt = pkt_off;
            wr_ptr = wr_ptr + pkt_off;
          end
          pkt_kept = 1'b0;
          pkt_off  = '0;
        end
        expected_results.push_back(make_result('0, 1'b0, 1'b1, acc, cnt));
      end
      OP_SKIP: begin
        rd_ptr = rd_ptr + n;
        expected_results.push_back(make_result('0, 1'b0, 1'b1, 1'b0, n));
      end
      default: begin
        if (n > MAX_BURST) n = LEN_W'(MAX_BURST);
        start = rd_ptr;
        if (n == 0) begin
          expected_results.push_back(make_result('0, 1'b0, 1'b1, 1'b0, '0));
        end else begin
          if (it.opcode == OP_READ) rd_ptr = rd_ptr + n;
          for (int i = 0; i < n; i++) begin
            slot = start + LEN_W'(i);
            expected_results.push_back(make_result(ring_mem[slot[ADDR_W-1:0]], 1'b1,
                                                   i + 1 == n, 1'b0, n));
          end
        end
      end
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t ERROR %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [LEN_W-1:0] got,
                             input logic [LEN_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d: %s got %0d want %0d", result_cnt, name, got, want));
  endtask

  // Monitor and predictor: outputs sampled at the rising edge
  always @(posedge clk) begin
    ring_result_t want;
    item_t        it;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", result_cnt));
        end else begin
          want = expected_results.pop_front();
          check_field("out_byte", LEN_W'(m_tdata[7:0]), LEN_W'(want.out_byte));
          check_field("count", m_tdata[20:8], want.info.count);
          check_field("available", m_tdata[33:21], want.info.available);
          check_field("free_space", m_tdata[46:34], want.info.free_space);
          check_field("byte_valid", LEN_W'(m_tuser[0]), LEN_W'(want.info.byte_valid));
          check_field("accepted", LEN_W'(m_tuser[1]), LEN_W'(want.info.accepted));
          check_field("last_result", LEN_W'(m_tlast), LEN_W'(want.info.last_result));
        end
        result_cnt++;
      end
      if (s_tvalid && s_tready) begin
        it.opcode         = op_t'(s_tuser[1:0]);
        it.first_byte     = s_tuser[2];
        it.last_byte      = s_tlast;
        it.data_byte      = s_tdata[7:0];
        it.packet_length  = s_tdata[20:8];
        it.request_length = s_tdata[33:21];
        predict_results(it);
        accept_cnt++;
      end
    end
  end

  // Driver: bursts with random gaps, changes at the falling edge
  int burst_left = 1;
  int gap_left = 0;

  always @(negedge clk) begin
    pending_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (offer_cnt == accept_cnt) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (pending_items.size() == 0 ||
                   (pending_items[0].idle_first && expected_results.size() != 0)) begin
        s_tvalid <= 1'b0;
      end else begin
        nxt = pending_items.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, nxt.it.request_length, nxt.it.packet_length, nxt.it.data_byte};
        s_tuser  <= {nxt.it.first_byte, nxt.it.opcode};
        s_tlast  <= nxt.it.last_byte;
        offer_cnt++;
        if (nxt.hold_rx) hold_req_cnt++;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // Receiver: stall pattern in phases, plus a long hold-off on request
  int hold_seen = 0;
  int hold_left = 0;
  int rx_mode = 0;
  int rx_mode_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (hold_req_cnt != hold_seen) begin
        hold_seen = hold_req_cnt;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode      = $urandom_range(0, 2);
          rx_mode_left = $urandom_range(5, 60);
        end
        rx_mode_left--;
        case (rx_mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= $urandom_range(0, 1);
          default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL atomic_byte_ring_fifo");
      $finish;
    end
  end

  task automatic queue_item(input op_t op, input int data, input int plen, input bit first,
                            input bit last, input int req, input bit idle_first = 1'b0,
                            input bit hold_rx = 1'b0);
    pending_t p;
    p.it.opcode         = op;
    p.it.data_byte      = BYTE_W'(data);
    p.it.packet_length  = LEN_W'(plen);
    p.it.first_byte     = first;
    p.it.last_byte      = last;
    p.it.request_length = LEN_W'(req);
    p.idle_first        = idle_first;
    p.hold_rx           = hold_rx;
    pending_items.push_back(p);
  endtask

  task automatic queue_write(input int data, input int plen, input bit first, input bit last);
    queue_item(OP_WRITE, data, plen, first, last, $urandom_range(0, 8191));
  endtask

  task automatic queue_request(input op_t op, input int req, input bit idle_first = 1'b0,
                               input bit hold_rx = 1'b0);
    queue_item(op, $urandom_range(0, 255), $urandom_range(0, 8191), $urandom_range(0, 1),
               $urandom_range(0, 1), req, idle_first, hold_rx);
  endtask

  // nbytes write transfers, declared length plen on the first
  task automatic queue_packet(input int nbytes, input int plen, input bit close = 1'b1);
    for (int i = 0; i < nbytes; i++)
      queue_write($urandom_range(0, 255), (i == 0) ? plen : $urandom_range(0, 8191),
                  i == 0, close && (i == nbytes - 1));
  endtask

  initial begin
    int n_items;
    int len;
    int plen;
    int pick;

    // directed: empty ring
    queue_request(OP_READ, 5);
    queue_request(OP_PEEK, 0);
    queue_request(OP_SKIP, 8191);
    queue_write(8'h3C, 12, 1'b0, 1'b0);        // no packet open
    queue_write(8'h11, 0, 1'b1, 1'b1);         // zero length
    queue_write(8'h00, 3, 1'b1, 1'b0);
    queue_write(8'hFF, 8191, 1'b0, 1'b0);
    queue_write(8'hA5, 0, 1'b0, 1'b1);
    queue_request(OP_PEEK, 2);
    queue_request(OP_READ, 0);
    queue_packet(4, 2);                        // extra bytes dropped
    queue_packet(2, 5);                        // closed early
    queue_packet(2, 4, 1'b0);                  // abandoned by the next first byte
    queue_packet(2, 2);
    queue_write(8'h77, 8191, 1'b1, 1'b1);      // far above the ring size
    queue_write(8'h78, 4097, 1'b1, 1'b0);
    queue_write(8'h79, 0, 1'b0, 1'b1);
    queue_request(OP_READ, 8191);
    queue_request(OP_SKIP, 1);
    queue_request(OP_SKIP, 8191);

    // declared length exactly at the free space, then one byte over it
    for (int pass = 0; pass < 2; pass++) begin
      queue_packet(8, 8);
      queue_write(8'h5A, DEPTH - 8 + pass, 1'b1, 1'b1);
      queue_request(OP_PEEK, 8191);
      queue_request(OP_READ, 100, 1'b0, pass == 0);
      queue_request(OP_SKIP, 8191, 1'b1);
    end

    // random traffic, mostly well-formed packets
    n_items = 0;
    while (n_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        len  = $urandom_range(1, 12);
        plen = len;
        case ($urandom_range(0, 9))
          7:       plen = len + $urandom_range(1, 3);
          8:       plen = len - 1;
          9:       plen = $urandom_range(0, 8191);
          default: ;
        endcase
        queue_packet(len, plen, $urandom_range(0, 19) != 0);
        n_items += len;
      end else if (pick < 80) begin
        queue_request(($urandom_range(0, 1) == 0) ? OP_READ : OP_PEEK,
                      ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191)
                                                  : $urandom_range(0, 70),
                      $urandom_range(0, 39) == 0);
        n_items++;
      end else if (pick < 88) begin
        queue_request(OP_SKIP, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
                                                           : $urandom_range(0, 20));
        n_items++;
      end else begin
        queue_item(op_t'($urandom_range(0, 3)), $urandom_range(0, 255),
                   $urandom_range(0, 8191), $urandom_range(0, 1), $urandom_range(0, 1),
                   $urandom_range(0, 8191));
        n_items++;
      end
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (pending_items.size() == 0 && offer_cnt == accept_cnt &&
          expected_results.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0)
      $display("PASS atomic_byte_ring_fifo");
    else
      $display("FAIL atomic_byte_ring_fifo");
    $finish;
  end

endmodule
